// ===== design/kcm_pkg.sv =====
// Shared constants, types and codes for the keypad code matcher.
package kcm_pkg;

	localparam int ENTRY_DEPTH      = 16;
	localparam int MAX_CODE_DIGITS  = 12;
	localparam int MIN_ENTRY_DIGITS = 6;
	localparam int DIGIT_KEYS       = 10;

	localparam int KEY_W      = 4;
	localparam int CODE_W     = 48;
	localparam int CODE_NIBS  = CODE_W / KEY_W;
	localparam int CODE_LEN_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CNT_W      = $clog2(ENTRY_DEPTH + 1);

	localparam logic [KEY_W-1:0] CONFIRM_KEY_RST = KEY_W'(11);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CODE_DIGITS = 2'd0,
		CFG_CODE_LENGTH = 2'd1,
		CFG_CONFIRM_KEY = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// per-cell control: shift toward cell 0, and whether the cell is in the code window
	typedef struct packed {
		logic shift;
		logic cmp_en;
	} cell_ctl_t;

endpackage

// ===== design/kcm_cell.sv =====
// One entry cell: holds a digit, shifts toward its lower neighbor, compares to a code digit.
module kcm_cell (
	input  logic                     clk,
	input  kcm_pkg::cell_ctl_t       ctl,
	input  logic [kcm_pkg::KEY_W-1:0] din,
	input  logic [kcm_pkg::KEY_W-1:0] code_nib,
	output logic [kcm_pkg::KEY_W-1:0] dout,
	output logic                     hit
);
	import kcm_pkg::*;

	logic [KEY_W-1:0] digit_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			digit_q <= din;
		end
	end

	assign dout = digit_q;
	// cells outside the code window never block a match
	assign hit  = !ctl.cmp_en || (digit_q == code_nib);

endmodule

// ===== design/keypad_code_matcher.sv =====
// Top level of the keypad code matcher: control, config registers and the cell row.
//
// Input channel: one beat per keypad event (key_value, is_press) on in_valid/in_stall.
// Output channel: exactly one beat per input beat (unlock, checked) on out_valid/out_stall.
// Config port: cfg_we with cfg_index (0 code digits, 1 code length, 2 confirm key) and
// cfg_data; index 3 is ignored. Write only while the block is idle.
//
// The entry lives in a row of ENTRY_DEPTH cells, newest digit in the top cell. A digit
// press shifts the row by one. A confirm press starts a scan: the row shifts toward cell 0
// once per cycle while the low cells are compared in parallel with the code, so each
// cycle tests one window position. The scan covers positions 0 to ENTRY_DEPTH - len (len
// being the code length capped at MAX_CODE_DIGITS) and leaves the row shifted out, which
// is fine because a confirm clears the entry anyway.
//
// A result goes from the internal result slot into the output register; a confirm beat's
// result is put in the slot when its scan ends. A new input beat is taken as soon as the
// internal result slot has moved into the output register, so one beat can be accepted
// while the previous result is stalled at the output, but not while a scan runs. When the
// receiver stalls, the output holds and input stalls once the slot fills.
// Reset clears the entry count, the registers to their defaults and both result slots.
module keypad_code_matcher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [kcm_pkg::KEY_W-1:0]           key_value,
	input  logic                                is_press,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                unlock,
	output logic                                checked,
	input  logic                                cfg_we,
	input  logic [kcm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kcm_pkg::CODE_W-1:0]          cfg_data
);
	import kcm_pkg::*;

	// config registers
	logic [CODE_W-1:0]     code_q;
	logic [CODE_LEN_W-1:0] code_len_q;
	logic [KEY_W-1:0]      confirm_q;

	// control state
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  scan_t_q, scan_t_d;
	logic              match_q, match_d;

	// result slot feeding the output register
	logic res_valid_q, res_valid_d;
	logic res_unlock_q, res_unlock_d;
	logic res_checked_q, res_checked_d;

	// cell row
	cell_ctl_t        ctl [ENTRY_DEPTH];
	logic [KEY_W-1:0] digits [ENTRY_DEPTH];
	logic [ENTRY_DEPTH-1:0] hits;
	logic [KEY_W-1:0] fill;
	logic             row_shift;

	logic             accept;
	logic             is_digit;
	logic [CNT_W-1:0] len_eff;
	logic [CNT_W-1:0] last_t;
	logic             pos_ok;
	logic             win_hit;
	logic             out_free;

	assign in_stall = (state_q != ST_IDLE) || res_valid_q;
	assign accept   = in_valid && !in_stall;
	assign is_digit = (key_value < KEY_W'(DIGIT_KEYS));

	// code length capped at what the code register can hold
	assign len_eff = (CNT_W'(code_len_q) > CNT_W'(MAX_CODE_DIGITS)) ?
		CNT_W'(MAX_CODE_DIGITS) : CNT_W'(code_len_q);
	assign last_t  = CNT_W'(ENTRY_DEPTH) - len_eff;

	// window at cells 0..len-1 maps to entry start t - (DEPTH - count): must be >= 0
	assign pos_ok  = ({1'b0, scan_t_q} + {1'b0, count_q}) >= (CNT_W + 1)'(ENTRY_DEPTH);
	assign win_hit = &hits;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q     <= '0;
			code_len_q <= '0;
			confirm_q  <= CONFIRM_KEY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CODE_DIGITS: code_q     <= cfg_data;
				CFG_CODE_LENGTH: code_len_q <= cfg_data[CODE_LEN_W-1:0];
				CFG_CONFIRM_KEY: confirm_q  <= cfg_data[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	// next state, row control and result slot
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		scan_t_d      = scan_t_q;
		match_d       = match_q;
		res_valid_d   = res_valid_q;
		res_unlock_d  = res_unlock_q;
		res_checked_d = res_checked_q;
		row_shift     = 1'b0;
		fill          = key_value;

		// slot drains into the output register when that is free
		if (res_valid_q && out_free) begin
			res_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_unlock_d  = 1'b0;
					res_checked_d = 1'b0;
					if (is_press && is_digit) begin
						row_shift   = 1'b1;
						res_valid_d = 1'b1;
						if (count_q != CNT_W'(ENTRY_DEPTH)) begin
							count_d = count_q + CNT_W'(1);
						end
					end else if (is_press && (key_value == confirm_q)) begin
						state_d  = ST_SCAN;
						scan_t_d = '0;
						match_d  = 1'b0;
					end else if (is_press) begin
						count_d     = '0;
						res_valid_d = 1'b1;
					end else begin
						res_valid_d = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				fill      = '0;
				row_shift = 1'b1;
				match_d   = match_q || (win_hit && pos_ok &&
					(count_q >= CNT_W'(MIN_ENTRY_DIGITS)));
				if (scan_t_q == last_t) begin
					state_d       = ST_IDLE;
					count_d       = '0;
					res_valid_d   = 1'b1;
					res_unlock_d  = match_d;
					res_checked_d = 1'b1;
				end else begin
					scan_t_d = scan_t_q + CNT_W'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_t_q    <= '0;
			match_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			scan_t_q    <= scan_t_d;
			match_q     <= match_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_unlock_q  <= res_unlock_d;
		res_checked_q <= res_checked_d;
	end

	// output register
	logic out_valid_q;
	logic out_unlock_q;
	logic out_checked_q;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid_q) begin
			out_unlock_q  <= res_unlock_q;
			out_checked_q <= res_checked_q;
		end
	end

	assign out_valid = out_valid_q;
	assign unlock    = out_unlock_q;
	assign checked   = out_checked_q;

	// cell row: cell i takes from cell i+1, the top cell takes the fill digit
	for (genvar i = 0; i < ENTRY_DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] cell_din;
		logic [KEY_W-1:0] cell_code;

		if (i == ENTRY_DEPTH - 1) begin : g_top
			assign cell_din = fill;
		end else begin : g_mid
			assign cell_din = digits[i+1];
		end

		if (i < CODE_NIBS) begin : g_code
			assign cell_code = code_q[KEY_W*i +: KEY_W];
		end else begin : g_nocode
			assign cell_code = '0;
		end

		assign ctl[i].shift  = row_shift;
		assign ctl[i].cmp_en = (state_q == ST_SCAN) && (CNT_W'(i) < len_eff);

		kcm_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.din      (cell_din),
			.code_nib (cell_code),
			.dout     (digits[i]),
			.hit      (hits[i])
		);
	end

`ifndef SYNTHESIS
	// an unlock is only ever reported on a confirm beat
	a_unlock_needs_check: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_unlock_q || out_checked_q))
		else $error("unlock without checked");

	// a checked result can only come out of a scan
	a_checked_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !$past(res_valid_q) && res_checked_q) |-> $past(state_q == ST_SCAN))
		else $error("checked result not produced by a scan");

	// entry count never exceeds the row depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRY_DEPTH))
		else $error("entry count out of range");

	// scan position stays within the last valid window
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_t_q <= last_t))
		else $error("scan ran past last window");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for keypad_code_matcher: directed table, then random code entry.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kcm_pkg::*;

	// Index past the end of the register list; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic unlock;
		logic checked;
	} outcome_t;

	localparam outcome_t OUT_QUIET    = '{unlock: 1'b0, checked: 1'b0};
	localparam outcome_t OUT_DENIED   = '{unlock: 1'b0, checked: 1'b1};
	localparam outcome_t OUT_UNLOCKED = '{unlock: 1'b1, checked: 1'b1};

	// Directed table rows: one key beat, a burst of digit presses, or a register write.
	typedef enum logic [1:0] {
		ROW_KEY,
		ROW_DIGITS,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;    // register index (ROW_CFG)
		logic [CODE_W-1:0]     data;   // register value, or digits low nibble first
		logic [KEY_W-1:0]      key;
		logic                  press;
		logic [3:0]            ndig;   // digit count (ROW_DIGITS)
		logic                  typed;  // use the outcome below instead of the predictor
		outcome_t              want;
	} row_t;

	localparam int N_DIRECTED = 20;
	localparam row_t DIRECTED [N_DIRECTED] = '{
		// reset settings: zero-length code, confirm on key 11
		'{ROW_KEY, '0, 48'h0, CONFIRM_KEY_RST, 1'b1, 4'd0, 1'b1, OUT_DENIED},  // empty entry
		'{ROW_KEY, '0, 48'h0, 4'd5, 1'b0, 4'd0, 1'b1, OUT_QUIET},    // release, ignored
		'{ROW_DIGITS, '0, 48'h90_9090, 4'd0, 1'b1, 4'd6, 1'b0, OUT_QUIET}, // 0 9 0 9 0 9
		'{ROW_KEY, '0, 48'h0, 4'd15, 1'b0, 4'd0, 1'b1, OUT_QUIET},   // release, ignored
		'{ROW_KEY, '0, 48'h0, CONFIRM_KEY_RST, 1'b1, 4'd0, 1'b1, OUT_UNLOCKED}, // any 6 digits
		'{ROW_DIGITS, '0, 48'h3, 4'd0, 1'b1, 4'd1, 1'b0, OUT_QUIET},
		'{ROW_KEY, '0, 48'h0, 4'd10, 1'b1, 4'd0, 1'b1, OUT_QUIET},   // plain clear
		'{ROW_KEY, '0, 48'h0, 4'd12, 1'b1, 4'd0, 1'b1, OUT_QUIET},
		'{ROW_KEY, '0, 48'h0, 4'd13, 1'b1, 4'd0, 1'b1, OUT_QUIET},
		'{ROW_KEY, '0, 48'h0, 4'd14, 1'b1, 4'd0, 1'b1, OUT_QUIET},
		'{ROW_KEY, '0, 48'h0, 4'd15, 1'b1, 4'd0, 1'b1, OUT_QUIET},
		// all-zero code, length past the cap, confirm on 15; spare index must not alias
		'{ROW_CFG, CFG_CODE_DIGITS, 48'h0, 4'd0, 1'b0, 4'd0, 1'b0, OUT_QUIET},
		'{ROW_CFG, CFG_CODE_LENGTH, 48'hF, 4'd0, 1'b0, 4'd0, 1'b0, OUT_QUIET},
		'{ROW_CFG, CFG_CONFIRM_KEY, 48'hF, 4'd0, 1'b0, 4'd0, 1'b0, OUT_QUIET},
		'{ROW_CFG, CFG_SPARE, 48'hA, 4'd0, 1'b0, 4'd0, 1'b0, OUT_QUIET},
		// twelve zeros match only if the length is capped at twelve
		'{ROW_DIGITS, '0, 48'h0, 4'd0, 1'b1, 4'd12, 1'b0, OUT_QUIET},
		'{ROW_KEY, '0, 48'h0, 4'd15, 1'b1, 4'd0, 1'b0, OUT_QUIET},
		// confirm set to a digit: it appends and never checks; 15 now just clears
		'{ROW_CFG, CFG_CONFIRM_KEY, 48'h5, 4'd0, 1'b0, 4'd0, 1'b0, OUT_QUIET},
		'{ROW_KEY, '0, 48'h0, 4'd5, 1'b1, 4'd0, 1'b0, OUT_QUIET},
		'{ROW_KEY, '0, 48'h0, 4'd15, 1'b1, 4'd0, 1'b0, OUT_QUIET}
	};

	// DUT signals: every input has a known value from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [KEY_W-1:0]     key_value = '0;
	logic                 is_press  = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 unlock;
	logic                 checked;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CODE_W-1:0]    cfg_data  = '0;

	keypad_code_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.key_value (key_value),
		.is_press  (is_press),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.unlock    (unlock),
		.checked   (checked),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: our own copy of the entry and of the three registers.
	logic [KEY_W-1:0]      entry_digit [ENTRY_DEPTH];
	int                    entry_len    = 0;
	logic [CODE_W-1:0]     code_reg     = '0;
	logic [CODE_LEN_W-1:0] code_len_reg = '0;
	logic [KEY_W-1:0]      confirm_reg  = CONFIRM_KEY_RST;

	outcome_t pending_outcomes [$];   // one per accepted beat, oldest first
	int       mismatches   = 0;
	int       presses_sent = 0;       // press beats only; releases don't count
	int       send_pct     = 0;       // chance per cycle that the sender holds off
	int       recv_pct     = 0;       // chance per cycle that the receiver stalls

	// Sliding-window search: does the code (capped length) appear anywhere in the entry?
	function automatic logic code_in_entry();
		int  len;
		bit  same;
		if (entry_len < MIN_ENTRY_DIGITS)
			return 1'b0;
		len = (code_len_reg > MAX_CODE_DIGITS) ? MAX_CODE_DIGITS : int'(code_len_reg);
		if (len > entry_len)
			return 1'b0;
		for (int s = 0; s + len <= entry_len; s++) begin
			same = 1'b1;
			for (int i = 0; i < len; i++)
				if (entry_digit[s + i] != code_reg[4*i +: 4])
					same = 1'b0;
			if (same)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Applies one keypad event to the predicted state and returns the outcome it causes.
	function automatic outcome_t keypad_outcome(input logic [KEY_W-1:0] k, input logic p);
		outcome_t res;
		res = OUT_QUIET;
		if (p) begin
			if (k < DIGIT_KEYS) begin
				if (entry_len < ENTRY_DEPTH) begin
					entry_digit[entry_len] = k;
					entry_len++;
				end else begin
					// full: oldest digit drops out at cell 0
					for (int i = 0; i < ENTRY_DEPTH - 1; i++)
						entry_digit[i] = entry_digit[i + 1];
					entry_digit[ENTRY_DEPTH - 1] = k;
				end
			end else begin
				if (k == confirm_reg) begin
					res.unlock  = code_in_entry();
					res.checked = 1'b1;
				end
				entry_len = 0;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		// keep the log bounded if the block goes badly wrong
		if (mismatches < 100)
			$display("%0t ns: MISMATCH %s", $realtime, msg);
		mismatches++;
	endtask

	// One input beat. Random hold-off first, then hold valid until the block takes it.
	// Valid stays high into the next call unless that call decides to idle.
	task automatic issue(input logic [KEY_W-1:0] k, input logic p,
			input bit typed = 1'b0, input outcome_t want = OUT_QUIET);
		outcome_t predicted;
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		key_value <= k;
		is_press  <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// beat accepted at this edge
		predicted = keypad_outcome(k, p);
		pending_outcomes.push_back(typed ? want : predicted);
		if (p)
			presses_sent++;
	endtask

	// Key press, sometimes preceded by a stray release event the block must ignore.
	task automatic press_key(input logic [KEY_W-1:0] k);
		if ($urandom_range(0, 11) == 0)
			issue(KEY_W'($urandom_range(0, 15)), 1'b0);
		issue(k, 1'b1);
	endtask

	// Register write. Only done with the block idle: every beat sent has come back.
	// Every beat yields a result, so an empty queue means nothing is in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] data);
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_CODE_DIGITS: code_reg     = data;
			CFG_CODE_LENGTH: code_len_reg = data[CODE_LEN_W-1:0];
			CFG_CONFIRM_KEY: confirm_reg  = data[KEY_W-1:0];
			default: ;
		endcase
	endtask

	// Well-formed attempt: decoys, the code (sometimes with one digit spoiled), decoys,
	// confirm. Long decoy runs push the entry past full so the oldest digits shift out.
	task automatic enter_attempt();
		int len, lead, trail, spoil;
		len   = (code_len_reg > MAX_CODE_DIGITS) ? MAX_CODE_DIGITS : int'(code_len_reg);
		lead  = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
		trail = $urandom_range(0, 4);
		spoil = (len > 0 && $urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
		repeat (lead)
			press_key(KEY_W'($urandom_range(0, 9)));
		for (int i = 0; i < len; i++)
			press_key((i == spoil) ? KEY_W'($urandom_range(0, 9)) : code_reg[4*i +: 4]);
		repeat (trail)
			press_key(KEY_W'($urandom_range(0, 9)));
		press_key(confirm_reg);
	endtask

	// Output side: compare each accepted beat with the oldest expectation, stall at random.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: unlock %0b checked %0b",
					unlock, checked));
			end else begin
				want = pending_outcomes.pop_front();
				if (unlock !== want.unlock)
					report_mismatch($sformatf("unlock %0b, expected %0b", unlock, want.unlock));
				if (checked !== want.checked)
					report_mismatch($sformatf("checked %0b, expected %0b",
						checked, want.checked));
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_pct);
	end

	initial begin : stimulus
		logic [CODE_W-1:0]     code_val;
		logic [CODE_LEN_W-1:0] len_val;
		logic [KEY_W-1:0]      key_val;
		int                    target;

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed part, no idling
		for (int r = 0; r < N_DIRECTED; r++) begin
			case (DIRECTED[r].kind)
				ROW_CFG: write_reg(DIRECTED[r].idx, DIRECTED[r].data);
				ROW_DIGITS: begin
					for (int i = 0; i < DIRECTED[r].ndig; i++)
						issue(DIRECTED[r].data[4*i +: 4], 1'b1);
				end
				default: issue(DIRECTED[r].key, DIRECTED[r].press,
					DIRECTED[r].typed, DIRECTED[r].want);
			endcase
		end

		// random part: eight settings, cycling through the four idling profiles
		for (int ph = 0; ph < 8; ph++) begin
			code_val = '0;
			for (int i = 0; i < CODE_NIBS; i++)
				code_val[4*i +: 4] = KEY_W'($urandom_range(0, 9));
			case (ph)
				0: begin
					len_val = 4'd6;
					key_val = 4'd10;
				end
				1: begin
					len_val = 4'd12;
					key_val = 4'd15;
				end
				2: begin
					// zero length: any entry of six or more digits opens
					len_val = 4'd0;
					key_val = CONFIRM_KEY_RST;
				end
				3: begin
					// function-key nibbles in the code: can never match
					code_val = {CODE_W{1'b1}};
					len_val  = 4'd6;
					key_val  = 4'd13;
				end
				4: begin
					code_val = '0;
					len_val  = 4'd15;
					key_val  = 4'd12;
				end
				5: begin
					// confirm on a digit key: no checks at all in this phase
					len_val = CODE_LEN_W'($urandom_range(1, 12));
					key_val = 4'd7;
				end
				default: begin
					if ($urandom_range(0, 1) == 0)
						code_val = CODE_W'({$urandom, $urandom});
					len_val = CODE_LEN_W'($urandom_range(0, 15));
					key_val = KEY_W'($urandom_range(10, 15));
				end
			endcase
			write_reg(CFG_CODE_DIGITS, code_val);
			write_reg(CFG_CODE_LENGTH, CODE_W'(len_val));
			write_reg(CFG_CONFIRM_KEY, CODE_W'(key_val));

			case (ph % 4)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 61; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 61; end
				default: begin send_pct = 32; recv_pct = 32; end
			endcase

			target = presses_sent + 65;
			while (presses_sent < target) begin
				if ($urandom_range(0, 9) < 7)
					enter_attempt();
				else
					repeat ($urandom_range(1, 8))
						issue(KEY_W'($urandom_range(0, 15)), $urandom_range(0, 3) != 0);
			end
		end

		// drain, then give a longest scan's worth of cycles for any stray beat to show
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);
		if (mismatches == 0)
			$display("keypad_code_matcher test passed");
		else
			$display("keypad_code_matcher test failed");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin : watchdog
		#(5_000_000);
		$display("keypad_code_matcher test failed");
		$finish;
	end

endmodule
